### rtl/attitude_sentence_field_parser_core_assert.svh
// assertion macros for the attitude sentence field parser
// no dependencies; included by the files that carry assertions
`ifndef ATTITUDE_SENTENCE_FIELD_PARSER_CORE_ASSERT_SVH
`define ATTITUDE_SENTENCE_FIELD_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ASFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asfp assertion failed");

// next-cycle implication, disabled in reset
`define ASFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asfp assertion failed");

`endif

### rtl/asfp_pkg.sv
// shared constants, types and arithmetic helpers of the attitude sentence parser
// no dependencies
package asfp_pkg;

   // number of decimal fraction digits kept in the fixed-point results (0..3)
   localparam int FRACTION_DIGITS = 1;
   localparam logic [1:0] FRAC_LIMIT = 2'(FRACTION_DIGITS);

   // characters
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // field numbers within a sentence
   localparam logic [2:0] FIELD_ID          = 3'd0;
   localparam logic [2:0] FIELD_HEADING     = 3'd1;
   localparam logic [2:0] FIELD_HEADING_FLG = 3'd2;
   localparam logic [2:0] FIELD_PITCH       = 3'd3;
   localparam logic [2:0] FIELD_PITCH_FLG   = 3'd4;
   localparam logic [2:0] FIELD_ROLL        = 3'd5;
   localparam logic [2:0] FIELD_ROLL_FLG    = 3'd6;
   localparam logic [2:0] FIELD_UNUSED      = 3'd7;

   // state of the number being read
   typedef struct packed {
      logic [15:0] acc;
      logic        neg;
      logic        point;
      logic [1:0]  frac;
      logic        stopped;
      logic        started;
   } num_state_type;

   localparam num_state_type NUM_CLEAR = '{acc: 16'd0, neg: 1'b0, point: 1'b0,
                                          frac: 2'd0, stopped: 1'b0, started: 1'b0};

   // mag * 10 + digit, saturating at 16 bits unsigned
   function automatic logic [15:0] times_ten_plus(input logic [15:0] mag,
                                                  input logic [3:0] digit);
      logic [19:0] v;
      v = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {16'd0, digit};
      return (v > 20'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   // scale to the kept fraction digits, apply the sign and clamp to 16 bits signed
   function automatic logic [15:0] finish_number(input num_state_type ns);
      logic [15:0] mag;
      logic [2:0]  n;
      mag = ns.acc;
      n   = {1'b0, ns.frac};
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
         if (n < 3'(FRACTION_DIGITS)) begin
            mag = times_ten_plus(mag, 4'd0);
            n   = n + 3'd1;
         end
      end
      if (ns.neg) begin
         return mag[15] ? 16'h8000 : 16'(~mag + 16'd1);
      end
      return mag[15] ? 16'h7FFF : mag;
   endfunction

endpackage

### rtl/asfp_if.sv
// channel interfaces of the attitude sentence parser: byte input and result output
// no dependencies
interface asfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface asfp_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] heading_tenths;
   logic signed [15:0] pitch_tenths;
   logic signed [15:0] roll_tenths;
   logic [7:0]        heading_flag;
   logic [7:0]        pitch_flag;
   logic [7:0]        roll_flag;

   modport source (output valid, output heading_tenths, output pitch_tenths,
                   output roll_tenths, output heading_flag, output pitch_flag,
                   output roll_flag, input ready);
   modport sink (input valid, input heading_tenths, input pitch_tenths,
                 input roll_tenths, input heading_flag, input pitch_flag,
                 input roll_flag, output ready);
endinterface

### rtl/asfp_num_unit.sv
// decimal number step: takes one character into the number state, and gives the
// finished fixed-point value; depends on asfp_pkg
module asfp_num_unit
   import asfp_pkg::*;
(
   input  num_state_type cur_state,
   input  logic [7:0]    char_in,
   output num_state_type nxt_state,
   output logic [15:0]   fin_value
);

   logic is_digit;
   logic is_blank;
   logic is_sign;

   assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign is_blank  = (char_in == CHAR_SPACE) || ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
   assign is_sign   = (char_in == CHAR_PLUS) || (char_in == CHAR_MINUS);
   assign fin_value = finish_number(cur_state);

   always_comb begin
      nxt_state = cur_state;
      if (!cur_state.stopped) begin
         if (is_digit) begin
            nxt_state.started = 1'b1;
            if (!cur_state.point) begin
               nxt_state.acc = times_ten_plus(cur_state.acc, char_in[3:0]);
            end else if (cur_state.frac < FRAC_LIMIT) begin
               nxt_state.acc  = times_ten_plus(cur_state.acc, char_in[3:0]);
               nxt_state.frac = cur_state.frac + 2'd1;
            end
         end else if ((char_in == CHAR_POINT) && !cur_state.point) begin
            nxt_state.point   = 1'b1;
            nxt_state.started = 1'b1;
         end else if (!cur_state.started && is_sign) begin
            nxt_state.neg     = (char_in == CHAR_MINUS);
            nxt_state.started = 1'b1;
         end else if (!cur_state.started && is_blank) begin
            nxt_state = cur_state;   // leading blank skipped
         end else begin
            nxt_state.stopped = 1'b1;
         end
      end
   end

endmodule

### rtl/attitude_sentence_field_parser_core.sv
// attitude sentence field parser, top level: input register, field sequencer and
// result register; depends on asfp_pkg, asfp_if and asfp_num_unit
//
// Takes one ASCII character per item from a comma-separated attitude sentence
// ($ID,heading,hflag,pitch,pflag,roll,rflag) and gives one result item per
// completed sentence: heading, pitch and roll as signed 16-bit values scaled by
// 10^FRACTION_DIGITS (tenths), truncated and saturated, plus the three status
// characters. A '$' restarts the sentence at any point. Throughput is one
// character per clock while input ready is high: the input register feeds a
// single pass of field and digit logic whose results land in the state
// registers and the result register. The sentence's last character is taken
// into the input register, then its result into the result register once that
// is free or being taken, so a waiting result that stays untaken holds it back.
// Input ready drops only when the input register holds a sentence-ending
// character and the result register is still full and not being taken.
`include "attitude_sentence_field_parser_core_assert.svh"

module attitude_sentence_field_parser_core
   import asfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   asfp_req_if.sink   req_chan,
   asfp_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // sentence state
   logic [2:0]    field_ff, field_in;
   num_state_type num_ff, num_in;
   logic [15:0]   held_heading_ff, held_heading_in;
   logic [15:0]   held_pitch_ff, held_pitch_in;
   logic [7:0]    held_hflag_ff, held_hflag_in;
   logic [7:0]    held_pflag_ff, held_pflag_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_heading_ff, rsp_heading_in;
   logic [15:0] rsp_pitch_ff, rsp_pitch_in;
   logic [15:0] rsp_roll_ff, rsp_roll_in;
   logic [7:0]  rsp_hflag_ff, rsp_hflag_in;
   logic [7:0]  rsp_pflag_ff, rsp_pflag_in;
   logic [7:0]  rsp_rflag_ff, rsp_rflag_in;

   // step control
   logic          is_dollar;
   logic          is_comma;
   logic          emit;       // the held character completes a sentence
   logic          advance;    // the held character is processed this cycle
   logic          req_fire;
   num_state_type num_step;
   logic [15:0]   fin_value;

   asfp_num_unit u_num (
      .cur_state (num_ff),
      .char_in   (in_byte_ff),
      .nxt_state (num_step),
      .fin_value (fin_value)
   );

   assign is_dollar = (in_byte_ff == CHAR_DOLLAR);
   assign is_comma  = (in_byte_ff == CHAR_COMMA);
   assign emit      = in_valid_ff && !is_dollar && (field_ff == FIELD_ROLL_FLG);
   // only a completing character waits on a full result register
   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // field sequencer
   always_comb begin
      field_in        = field_ff;
      num_in          = num_ff;
      held_heading_in = held_heading_ff;
      held_pitch_in   = held_pitch_ff;
      held_hflag_in   = held_hflag_ff;
      held_pflag_in   = held_pflag_ff;
      if (advance) begin
         if (is_dollar) begin
            // restart; held values stay
            field_in = FIELD_ID;
            num_in   = NUM_CLEAR;
         end else begin
            case (field_ff)
               FIELD_ROLL_FLG: begin
                  field_in = FIELD_ID;
                  num_in   = NUM_CLEAR;
               end
               FIELD_HEADING, FIELD_PITCH, FIELD_ROLL: begin
                  if (is_comma) begin
                     num_in   = NUM_CLEAR;
                     field_in = field_ff + 3'd1;
                     if (field_ff == FIELD_HEADING) begin
                        held_heading_in = fin_value;
                     end else if (field_ff == FIELD_PITCH) begin
                        held_pitch_in = fin_value;
                     end else begin
                        // finished roll waits in the accumulator
                        num_in.acc = fin_value;
                     end
                  end else begin
                     num_in = num_step;
                  end
               end
               FIELD_HEADING_FLG, FIELD_PITCH_FLG: begin
                  // first character of the field is the status, even a comma
                  if (!num_ff.stopped) begin
                     num_in.stopped = 1'b1;
                     if (field_ff == FIELD_HEADING_FLG) begin
                        held_hflag_in = in_byte_ff;
                     end else begin
                        held_pflag_in = in_byte_ff;
                     end
                  end
                  if (is_comma) begin
                     num_in   = NUM_CLEAR;
                     field_in = field_ff + 3'd1;
                  end
               end
               default: begin
                  // sentence id field: wait for the first comma
                  if (is_comma) begin
                     num_in   = NUM_CLEAR;
                     field_in = FIELD_HEADING;
                  end
               end
            endcase
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_heading_in = rsp_heading_ff;
      rsp_pitch_in   = rsp_pitch_ff;
      rsp_roll_in    = rsp_roll_ff;
      rsp_hflag_in   = rsp_hflag_ff;
      rsp_pflag_in   = rsp_pflag_ff;
      rsp_rflag_in   = rsp_rflag_ff;
      if (advance && emit) begin
         rsp_valid_in   = 1'b1;
         rsp_heading_in = held_heading_ff;
         rsp_pitch_in   = held_pitch_ff;
         rsp_roll_in    = num_ff.acc;
         rsp_hflag_in   = held_hflag_ff;
         rsp_pflag_in   = held_pflag_ff;
         rsp_rflag_in   = in_byte_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         field_ff        <= FIELD_ID;
         num_ff          <= NUM_CLEAR;
         held_heading_ff <= 16'd0;
         held_pitch_ff   <= 16'd0;
         held_hflag_ff   <= 8'd0;
         held_pflag_ff   <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         field_ff        <= field_in;
         num_ff          <= num_in;
         held_heading_ff <= held_heading_in;
         held_pitch_ff   <= held_pitch_in;
         held_hflag_ff   <= held_hflag_in;
         held_pflag_ff   <= held_pflag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_pitch_ff   <= rsp_pitch_in;
      rsp_roll_ff    <= rsp_roll_in;
      rsp_hflag_ff   <= rsp_hflag_in;
      rsp_pflag_ff   <= rsp_pflag_in;
      rsp_rflag_ff   <= rsp_rflag_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.heading_tenths = rsp_heading_ff;
   assign rsp_chan.pitch_tenths   = rsp_pitch_ff;
   assign rsp_chan.roll_tenths    = rsp_roll_ff;
   assign rsp_chan.heading_flag   = rsp_hflag_ff;
   assign rsp_chan.pitch_flag     = rsp_pflag_ff;
   assign rsp_chan.roll_flag      = rsp_rflag_ff;

   // the field counter never reaches the unused code
   `ASFP_ASSERT_NOW(a_field_range, clock, reset, 1'b1, field_ff != FIELD_UNUSED)
   // a completed sentence shows a result next cycle and goes back to the id field
   `ASFP_ASSERT_NEXT(a_emit_result, clock, reset, advance && emit,
      rsp_valid_ff && (field_ff == FIELD_ID))
   // a waiting result is never overwritten
   `ASFP_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready && emit,
      !advance)
   // a restart clears the field counter and the number
   `ASFP_ASSERT_NEXT(a_restart, clock, reset, advance && is_dollar,
      (field_ff == FIELD_ID) && (num_ff == NUM_CLEAR))

endmodule

### dv/attitude_sentence_field_parser_core_test.sv
// testbench for the attitude sentence field parser: streams sentence characters,
// predicts every completed sentence and checks each result item against it
// depends on asfp_pkg, asfp_if and attitude_sentence_field_parser_core
module attitude_sentence_field_parser_core_test;
   import asfp_pkg::*;

   // idle cycles with no item accepted before the run is declared hung
   localparam int HANG_LIMIT = 1000;
   // random part size, in characters
   localparam int RANDOM_BYTES = 1350;
   // no idling once this few characters remain
   localparam int QUIET_TAIL = 120;
   // cycles allowed after the last expectation clears
   localparam int DRAIN_CYCLES = 12;
   // blank characters run from tab up to carriage return
   localparam logic [7:0] BLANK_LO = CHAR_TAB;
   localparam logic [7:0] BLANK_HI = CHAR_CR;

   typedef struct {
      logic [15:0] heading;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [7:0]  hflag;
      logic [7:0]  pflag;
      logic [7:0]  rflag;
   } attitude_fix_type;

   logic clock;
   logic reset;

   asfp_req_if req_chan ();
   asfp_rsp_if rsp_chan ();

   attitude_sentence_field_parser_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // characters waiting to be sent, and the sentence being assembled
   logic [7:0] chars_to_send[$];
   logic [7:0] sentence_buf[$];
   // attitudes the block still owes us, oldest first
   attitude_fix_type attitudes_due[$];

   int  error_count;
   int  chars_taken;
   int  attitudes_checked;
   int  hang_count;
   logic req_fire;

   // parser shadow state
   logic [2:0]  fld;
   logic [15:0] acc;
   logic        neg;
   logic        pnt;
   logic [1:0]  frac;
   logic        stopped;
   logic        started;
   logic [15:0] hold_heading;
   logic [15:0] hold_pitch;
   logic [7:0]  hold_hflag;
   logic [7:0]  hold_pflag;

   // ---------------------------------------------------------------- clock, reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   // times ten plus a digit, pinned at the 16-bit unsigned top
   function automatic logic [15:0] mag_push(input logic [15:0] mag, input int digit);
      int v;
      v = int'(mag) * 10 + digit;
      return (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   // scale out missing fraction digits, apply the sign, clamp to signed 16 bits
   function automatic logic [15:0] scaled_angle();
      int m;
      m = int'(acc);
      for (int n = int'(frac); n < FRACTION_DIGITS; n++)
         m = int'(mag_push(16'(m), 0));
      if (neg)
         return (m >= 32768) ? 16'h8000 : 16'(-m);
      return (m > 32767) ? 16'h7FFF : 16'(m);
   endfunction

   function automatic void drop_number();
      acc     = 16'd0;
      neg     = 1'b0;
      pnt     = 1'b0;
      frac    = 2'd0;
      stopped = 1'b0;
      started = 1'b0;
   endfunction

   // one character inside a heading, pitch or roll field
   function automatic void number_char(input logic [7:0] c);
      if (stopped)
         return;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         started = 1'b1;
         if (!pnt) begin
            acc = mag_push(acc, int'(c - CHAR_ZERO));
         end else if (int'(frac) < FRACTION_DIGITS) begin
            acc  = mag_push(acc, int'(c - CHAR_ZERO));
            frac = frac + 2'd1;
         end
      end else if (c == CHAR_POINT && !pnt) begin
         pnt     = 1'b1;
         started = 1'b1;
      end else if (!started && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
         neg     = (c == CHAR_MINUS);
         started = 1'b1;
      end else if (!started && (c == CHAR_SPACE || (c >= BLANK_LO && c <= BLANK_HI))) begin
         // leading blanks are skipped
      end else begin
         stopped = 1'b1;
      end
   endfunction

   // advance the shadow parser by one accepted character
   function automatic void parse_char(input logic [7:0] c);
      attitude_fix_type a;
      logic [15:0]      v;
      if (c == CHAR_DOLLAR) begin
         // restart anywhere; held values survive
         fld = FIELD_ID;
         drop_number();
         return;
      end
      case (fld)
         FIELD_ROLL_FLG: begin
            // any character here completes the sentence, a comma too
            a.heading = hold_heading;
            a.pitch   = hold_pitch;
            a.roll    = acc;
            a.hflag   = hold_hflag;
            a.pflag   = hold_pflag;
            a.rflag   = c;
            attitudes_due.push_back(a);
            fld = FIELD_ID;
            drop_number();
         end
         FIELD_HEADING, FIELD_PITCH, FIELD_ROLL: begin
            if (c == CHAR_COMMA) begin
               v = scaled_angle();
               drop_number();
               if (fld == FIELD_HEADING)
                  hold_heading = v;
               else if (fld == FIELD_PITCH)
                  hold_pitch = v;
               else
                  acc = v;   // roll waits in the accumulator
               fld = fld + 3'd1;
            end else begin
               number_char(c);
            end
         end
         FIELD_HEADING_FLG, FIELD_PITCH_FLG: begin
            // first character is the status, an immediate comma included
            if (!stopped) begin
               if (fld == FIELD_HEADING_FLG)
                  hold_hflag = c;
               else
                  hold_pflag = c;
               stopped = 1'b1;
            end
            if (c == CHAR_COMMA) begin
               drop_number();
               fld = fld + 3'd1;
            end
         end
         default: begin
            // talker id: skip to the first comma
            if (c == CHAR_COMMA) begin
               drop_number();
               fld = FIELD_HEADING;
            end
         end
      endcase
   endfunction

   function automatic void report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_attitude();
      attitude_fix_type a;
      if (attitudes_due.size() == 0) begin
         $display("%0t: unexpected result item, expected none, actual heading %0d",
                  $time, $signed(rsp_chan.heading_tenths));
         error_count++;
         return;
      end
      a = attitudes_due.pop_front();
      report_field("heading_tenths", int'($signed(a.heading)), int'(rsp_chan.heading_tenths));
      report_field("pitch_tenths", int'($signed(a.pitch)), int'(rsp_chan.pitch_tenths));
      report_field("roll_tenths", int'($signed(a.roll)), int'(rsp_chan.roll_tenths));
      report_field("heading_flag", int'(a.hflag), int'(rsp_chan.heading_flag));
      report_field("pitch_flag", int'(a.pflag), int'(rsp_chan.pitch_flag));
      report_field("roll_flag", int'(a.rflag), int'(rsp_chan.roll_flag));
      attitudes_checked++;
   endfunction

   // ---------------------------------------------------------------- stimulus builders
   // any byte that neither restarts nor ends a field
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_DOLLAR || b == CHAR_COMMA);
      return b;
   endfunction

   function automatic void add_str(input string s);
      for (int i = 0; i < s.len(); i++)
         sentence_buf.push_back(s[i]);
   endfunction

   function automatic void add_digit();
      sentence_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   // a numeric field with random shape: blanks, sign, digits, point, fraction, junk
   function automatic void add_number();
      int n_int;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 2))
            sentence_buf.push_back(($urandom_range(0, 1) == 0) ? CHAR_SPACE
                                   : 8'($urandom_range(BLANK_LO, BLANK_HI)));
      end
      case ($urandom_range(0, 3))
         0: sentence_buf.push_back(CHAR_MINUS);
         1: sentence_buf.push_back(CHAR_PLUS);
         default: ;
      endcase
      // mostly everyday sizes, sometimes long enough to saturate
      n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      repeat (n_int) add_digit();
      if ($urandom_range(0, 1) == 0) begin
         sentence_buf.push_back(CHAR_POINT);
         repeat ($urandom_range(0, 3)) add_digit();
      end
      if ($urandom_range(0, 7) == 0) begin
         // trailing junk, may itself look numeric
         repeat ($urandom_range(1, 3))
            sentence_buf.push_back(($urandom_range(0, 1) == 0) ? plain_byte()
                                   : CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endfunction

   // a status field: usually one character, sometimes empty, sometimes longer
   function automatic void add_status();
      if ($urandom_range(0, 7) == 0)
         return;
      sentence_buf.push_back(plain_byte());
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) sentence_buf.push_back(plain_byte());
   endfunction

   // one sentence, whole or cut short, followed now and then by line noise
   function automatic void add_sentence();
      int keep;
      logic [7:0] last;
      sentence_buf.delete();
      if ($urandom_range(0, 7) != 0)
         sentence_buf.push_back(CHAR_DOLLAR);
      repeat ($urandom_range(0, 5)) sentence_buf.push_back(plain_byte());
      sentence_buf.push_back(CHAR_COMMA);
      add_number();
      sentence_buf.push_back(CHAR_COMMA);
      add_status();
      sentence_buf.push_back(CHAR_COMMA);
      add_number();
      sentence_buf.push_back(CHAR_COMMA);
      add_status();
      sentence_buf.push_back(CHAR_COMMA);
      add_number();
      sentence_buf.push_back(CHAR_COMMA);
      // roll status may be anything but a restart, a comma included
      do last = 8'($urandom_range(0, 255));
      while (last == CHAR_DOLLAR);
      sentence_buf.push_back(last);
      if ($urandom_range(0, 1) == 0)
         add_str("\r\n");
      keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, sentence_buf.size())
                                         : sentence_buf.size();
      for (int i = 0; i < keep; i++)
         chars_to_send.push_back(sentence_buf[i]);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 8)) chars_to_send.push_back(8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------- main sequence
   initial begin
      error_count       = 0;
      chars_taken       = 0;
      attitudes_checked = 0;
      fld          = FIELD_ID;
      drop_number();
      hold_heading = 16'd0;
      hold_pitch   = 16'd0;
      hold_hflag   = 8'd0;
      hold_pflag   = 8'd0;

      // directed: heading saturates high, empty heading status, lone sign and point,
      // all-ones pitch status, extra roll digits truncated, all-zeros roll status
      sentence_buf.delete();
      add_str(",9999,,-.,");
      sentence_buf.push_back(8'hFF);
      add_str(",+1.99,");
      sentence_buf.push_back(8'h00);
      // heading saturates low, hex form reads zero, exponent stops the roll number,
      // restart inside a status field, comma as roll status
      add_str("$,-99999,A$,-99999,A,0x1A,,1e2,,");
      foreach (sentence_buf[i]) chars_to_send.push_back(sentence_buf[i]);

      while (chars_to_send.size() < RANDOM_BYTES)
         add_sentence();

      // let everything out, then let the pipeline settle
      wait (!reset);
      wait (chars_to_send.size() == 0 && !req_chan.valid);
      wait (attitudes_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d characters, checked %0d attitude results, %0d mismatches",
               chars_taken, attitudes_checked, error_count);
      if (error_count == 0 && attitudes_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver
   int send_gap;
   int hold_gap;

   // characters change at the falling edge, with idle bursts at random
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (chars_to_send.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 4);
            req_chan.valid <= 1'b0;
         end else if (chars_to_send.size() > 0) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= chars_to_send.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result side stalls in bursts too, but not near the end
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_gap = 0;
      end else if (hold_gap > 0) begin
         hold_gap--;
         rsp_chan.ready <= 1'b0;
      end else if (chars_to_send.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         hold_gap = $urandom_range(0, 4);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor
   // accepted characters feed the shadow parser, accepted results are checked
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            parse_char(req_chan.rx_byte);
            chars_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready)
            check_attitude();
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, HANG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

endmodule
